// ----- hw/rtl/cam_pkg.sv -----
// shared constants, types and helpers of the circular avatar mask
package cam_pkg;

  // image geometry
  localparam int unsigned IMAGE_SIZE   = 144;
  localparam int unsigned BORDER_WIDTH = 4;

  // port widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned CROP_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // pixel index, column and row
  localparam int unsigned IDX_W   = POS_W - 1;
  localparam int unsigned COL_W   = $clog2(IMAGE_SIZE);
  localparam int unsigned ROW_MAX = (2 ** IDX_W - 1) / IMAGE_SIZE;
  localparam int unsigned ROW_W   = $clog2(ROW_MAX + 1);
  localparam int unsigned CMP_W   = (ROW_W > CROP_W) ? ROW_W : CROP_W;

  // circle constants
  localparam int unsigned CENTER = IMAGE_SIZE / 2;
  localparam int unsigned RADIUS = (CENTER > BORDER_WIDTH) ? CENTER - BORDER_WIDTH : 0;
  localparam int unsigned LO     = RADIUS * RADIUS;
  localparam int unsigned HI     = CENTER * CENTER;
  localparam int unsigned DEN    = HI - LO;

  // distance datapath widths
  localparam int unsigned MAG_W = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int unsigned SQ_W  = 2 * MAG_W;
  localparam int unsigned D_W   = SQ_W + 1;
  localparam int unsigned NUM_W = $clog2(31 * DEN + 1);

  // reciprocal for the row split (quotient low by at most one)
  localparam int unsigned ROW_K   = IDX_W + 1;
  localparam int unsigned ROW_M   = (2 ** ROW_K) / IMAGE_SIZE;
  localparam int unsigned ROW_M_W = $clog2(ROW_M + 1);
  localparam int unsigned ROW_P_W = IDX_W + ROW_M_W;

  // reciprocal for the ring scale (quotient low by at most one)
  localparam int unsigned S_K   = NUM_W + 1;
  localparam int unsigned S_M   = (2 ** S_K) / DEN;
  localparam int unsigned S_M_W = $clog2(S_M + 1);
  localparam int unsigned S_P_W = NUM_W + S_M_W;

  // blend widths
  localparam int unsigned SHADE_W = 5;
  localparam int unsigned TONE_W  = 4;
  localparam int unsigned RB_W    = 9;
  localparam int unsigned G_W     = 10;

  // exact divide by 15 for sums below 1024
  localparam int unsigned DIV15_K = 18;
  localparam int unsigned DIV15_M = 17477;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG    = 3'd0,
    CFG_BG    = 3'd1,
    CFG_X_MIN = 3'd2,
    CFG_X_MAX = 3'd3,
    CFG_Y_MIN = 3'd4,
    CFG_Y_MAX = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0]  fg;
    logic [PIX_W-1:0]  bg;
    logic [CROP_W-1:0] x_min;
    logic [CROP_W-1:0] x_max;
    logic [CROP_W-1:0] y_min;
    logic [CROP_W-1:0] y_max;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic take_even;
    logic take_odd;
    logic ld_div;
    logic ld_rc;
    logic ld_sq;
    logic ld_sum;
    logic ld_cls;
    logic ld_rcp;
    logic ld_quo;
    logic ld_mix;
    logic ld_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_window;
  } sts_t;

  function automatic logic [5:0] div15(input logic [G_W-1:0] x);
    logic [G_W+DIV15_K-1:0] prod;
    prod = (G_W + DIV15_K)'(x) * (G_W + DIV15_K)'(DIV15_M);
    return 6'(prod >> DIV15_K);
  endfunction

endpackage

// ----- hw/rtl/cam_regs.sv -----
// configuration registers of the circular avatar mask
module cam_regs
  import cam_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FG:    cfg_d.fg    = cfg_wdata_i[PIX_W-1:0];
        CFG_BG:    cfg_d.bg    = cfg_wdata_i[PIX_W-1:0];
        CFG_X_MIN: cfg_d.x_min = cfg_wdata_i[CROP_W-1:0];
        CFG_X_MAX: cfg_d.x_max = cfg_wdata_i[CROP_W-1:0];
        CFG_Y_MIN: cfg_d.y_min = cfg_wdata_i[CROP_W-1:0];
        CFG_Y_MAX: cfg_d.y_max = cfg_wdata_i[CROP_W-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fg    <= '0;
      cfg_q.bg    <= '0;
      cfg_q.x_min <= '0;
      cfg_q.x_max <= CROP_W'(IMAGE_SIZE - 1);
      cfg_q.y_min <= '0;
      cfg_q.y_max <= CROP_W'(IMAGE_SIZE - 1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/cam_dp.sv -----
// datapath: position split, crop test, distance, ring scale and blend
module cam_dp
  import cam_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [POS_W-1:0]  byte_pos_i,
  input  cfg_t              cfg_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [PIX_W-1:0]  pixel_o
);

  logic [BYTE_W-1:0]  hb_q;
  logic [IDX_W-1:0]   idx_q;
  logic [PIX_W-1:0]   pix_q;
  logic [ROW_P_W-1:0] prodr_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [SQ_W-1:0]    dx2_q, dy2_q;
  logic [D_W-1:0]     d_q;
  logic               lt_lo_q, gt_hi_q;
  logic [NUM_W-1:0]   num_q;
  logic [S_P_W-1:0]   prods_q;
  logic [SHADE_W-1:0] s_q;
  logic [RB_W-1:0]    sr_q, sb_q;
  logic [G_W-1:0]     sg_q;
  logic [PIX_W-1:0]   res_q;

  // high byte store, the only state with a reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q <= '0;
    end else if (cmd_i.take_even) begin
      hb_q <= data_byte_i;
    end
  end

  // row split: quotient estimate, then one correction step
  logic [IDX_W-1:0] qr_est, rem_est;
  logic             rem_over;
  assign qr_est   = IDX_W'(prodr_q >> ROW_K);
  assign rem_est  = idx_q - IDX_W'(qr_est * IMAGE_SIZE);
  assign rem_over = (rem_est >= IDX_W'(IMAGE_SIZE));

  // crop window test on the split position
  assign sts_o.in_window = (CMP_W'(col_q) >= CMP_W'(cfg_i.x_min)) &&
                           (CMP_W'(col_q) <= CMP_W'(cfg_i.x_max)) &&
                           (CMP_W'(row_q) >= CMP_W'(cfg_i.y_min)) &&
                           (CMP_W'(row_q) <= CMP_W'(cfg_i.y_max));

  // distance magnitudes from the center
  logic [MAG_W-1:0] colx, rowx, cen, adx, ady;
  assign colx = MAG_W'(col_q);
  assign rowx = MAG_W'(row_q);
  assign cen  = MAG_W'(CENTER);
  assign adx  = (colx >= cen) ? colx - cen : cen - colx;
  assign ady  = (rowx >= cen) ? rowx - cen : cen - rowx;

  // ring scale correction
  logic [NUM_W-1:0] qs_est, rs_est, qs_fix;
  assign qs_est = NUM_W'(prods_q >> S_K);
  assign rs_est = num_q - NUM_W'(qs_est * DEN);
  assign qs_fix = (rs_est >= NUM_W'(DEN)) ? qs_est + NUM_W'(1) : qs_est;

  // blend operand choice, outer half of the ring fades to background
  logic              outer;
  logic [TONE_W-1:0] tone, tone_inv;
  logic [PIX_W-1:0]  mix_a, mix_b;
  assign outer    = s_q[SHADE_W-1];
  assign tone     = s_q[TONE_W-1:0];
  assign tone_inv = TONE_W'(15) - tone;
  assign mix_a    = outer ? cfg_i.bg : cfg_i.fg;
  assign mix_b    = outer ? cfg_i.fg : pix_q;

  // per-channel divide by 15 and result select
  logic [5:0]       dr, dg, db;
  logic [PIX_W-1:0] blended, result;
  assign dr      = div15(G_W'(sr_q));
  assign dg      = div15(sg_q);
  assign db      = div15(G_W'(sb_q));
  assign blended = {dr[4:0], dg[5:0], db[4:0]};
  assign result  = lt_lo_q ? pix_q : (gt_hi_q ? cfg_i.bg : blended);

  // datapath registers, each loaded by its own command
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_odd) begin
      idx_q <= byte_pos_i[POS_W-1:1];
      pix_q <= {hb_q, data_byte_i};
    end
    if (cmd_i.ld_div) begin
      prodr_q <= ROW_P_W'(idx_q) * ROW_P_W'(ROW_M);
    end
    if (cmd_i.ld_rc) begin
      row_q <= rem_over ? ROW_W'(qr_est + IDX_W'(1)) : ROW_W'(qr_est);
      col_q <= rem_over ? COL_W'(rem_est - IDX_W'(IMAGE_SIZE)) : COL_W'(rem_est);
    end
    if (cmd_i.ld_sq) begin
      dx2_q <= SQ_W'(adx) * SQ_W'(adx);
      dy2_q <= SQ_W'(ady) * SQ_W'(ady);
    end
    if (cmd_i.ld_sum) begin
      d_q <= D_W'(dx2_q) + D_W'(dy2_q);
    end
    if (cmd_i.ld_cls) begin
      lt_lo_q <= (d_q < D_W'(LO));
      gt_hi_q <= (d_q > D_W'(HI));
      num_q   <= NUM_W'(NUM_W'(d_q - D_W'(LO)) * NUM_W'(31));
    end
    if (cmd_i.ld_rcp) begin
      prods_q <= S_P_W'(num_q) * S_P_W'(S_M);
    end
    if (cmd_i.ld_quo) begin
      s_q <= SHADE_W'(qs_fix);
    end
    if (cmd_i.ld_mix) begin
      sr_q <= RB_W'(mix_a[15:11]) * RB_W'(tone) + RB_W'(mix_b[15:11]) * RB_W'(tone_inv);
      sg_q <= G_W'(mix_a[10:5]) * G_W'(tone) + G_W'(mix_b[10:5]) * G_W'(tone_inv);
      sb_q <= RB_W'(mix_a[4:0]) * RB_W'(tone) + RB_W'(mix_b[4:0]) * RB_W'(tone_inv);
    end
    if (cmd_i.ld_out) begin
      res_q <= result;
    end
  end

  assign pixel_o = res_q;

endmodule

// ----- hw/rtl/cam_ctrl.sv -----
// controller: request handshakes and the per-pixel step sequence
module cam_ctrl
  import cam_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic pos_odd_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_DIVM = 10'b00_0000_0010,
    S_DIVC = 10'b00_0000_0100,
    S_SQR  = 10'b00_0000_1000,
    S_SUM  = 10'b00_0001_0000,
    S_CLS  = 10'b00_0010_0000,
    S_RCP  = 10'b00_0100_0000,
    S_QUO  = 10'b00_1000_0000,
    S_MIX  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   acc, out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (acc && pos_odd_i) state_d = S_DIVM;
      S_DIVM:  state_d = S_DIVC;
      S_DIVC:  state_d = S_SQR;
      S_SQR:   state_d = sts_i.in_window ? S_SUM : S_IDLE;
      S_SUM:   state_d = S_CLS;
      S_CLS:   state_d = S_RCP;
      S_RCP:   state_d = S_QUO;
      S_QUO:   state_d = S_MIX;
      S_MIX:   state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.take_even = acc && !pos_odd_i;
    cmd_o.take_odd  = acc && pos_odd_i;
    cmd_o.ld_div    = (state_q == S_DIVM);
    cmd_o.ld_rc     = (state_q == S_DIVC);
    cmd_o.ld_sq     = (state_q == S_SQR);
    cmd_o.ld_sum    = (state_q == S_SUM);
    cmd_o.ld_cls    = (state_q == S_CLS);
    cmd_o.ld_rcp    = (state_q == S_RCP);
    cmd_o.ld_quo    = (state_q == S_QUO);
    cmd_o.ld_mix    = (state_q == S_MIX);
    cmd_o.ld_out    = (state_q == S_DONE) && out_free;
  end

  // output request flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // an odd request always starts the sequence
  a_odd_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && pos_odd_i) |=> (state_q == S_DIVM))
    else $error("odd request did not start the pixel sequence");

  // an even request only stores the high byte
  a_even_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !pos_odd_i) |=> (state_q == S_IDLE))
    else $error("even request left the idle state");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |-> (!out_valid_q || out_ready_i))
    else $error("result register loaded while a result waits");

  // a taken result with nothing new behind it clears the request
  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !cmd_o.ld_out) |=> !out_valid_o)
    else $error("result request stayed after it was taken");

endmodule

// ----- hw/rtl/circular_avatar_mask.sv -----
// top level of the circular avatar mask
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   cfg      | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//   in       | in_valid_i / in_ready_o   | data_byte_i, byte_pos_i
//   out      | out_valid_o / out_ready_i | pixel_o
//
// an even byte request only stores the high byte; an odd one runs the step
// sequence through reciprocal divides, squares and blend to the result
// register, and gives no result when the pixel falls outside the crop window.
// rst_ni clears the control state, the high byte and the configuration registers.
// the result register holds a pending pixel while the next bytes come in;
// the sequence waits in its last step only while that register is full.
module circular_avatar_mask
  import cam_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic [POS_W-1:0]      byte_pos_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      pixel_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // configuration registers
  cam_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sequence controller
  cam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .pos_odd_i   (byte_pos_i[0]),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // pixel datapath
  cam_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (data_byte_i),
    .byte_pos_i  (byte_pos_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pixel_o     (pixel_o)
  );

endmodule

// ----- dv/tb_circular_avatar_mask.sv -----
// self-checking testbench for the circular avatar mask with its own pixel predictor
`timescale 1ns / 100ps

module tb_circular_avatar_mask;
  import cam_pkg::*;

  // circle geometry as the predictor sees it
  localparam int CTR     = int'(IMAGE_SIZE / 2);
  localparam int RAD     = (CTR > int'(BORDER_WIDTH)) ? CTR - int'(BORDER_WIDTH) : 0;
  localparam int RING_LO = RAD * RAD;
  localparam int RING_HI = CTR * CTR;

  // register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
  } byte_req_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx     = CFG_FG;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic [BYTE_W-1:0]     byte_data   = '0;
  logic [POS_W-1:0]      byte_pos    = '0;
  logic                  out_ready   = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [PIX_W-1:0]      pixel_o;

  // predictor copy of the registers and the stored high byte
  logic [PIX_W-1:0]  ring_rgb    = '0;
  logic [PIX_W-1:0]  outside_rgb = '0;
  logic [CROP_W-1:0] win_col_lo  = 8'd0;
  logic [CROP_W-1:0] win_col_hi  = 8'd143;
  logic [CROP_W-1:0] win_row_lo  = 8'd0;
  logic [CROP_W-1:0] win_row_hi  = 8'd143;
  logic [BYTE_W-1:0] saved_high_byte = '0;

  byte_req_t        byte_reqs_pending[$];
  logic [PIX_W-1:0] expected_pixels[$];
  byte_req_t        next_req;
  logic [PIX_W-1:0] want_pixel;

  int send_gap_pct   = 35;
  int recv_stall_pct = 62;
  int bytes_sent     = 0;
  int pixels_checked = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int settings_run   = 0;

  circular_avatar_mask u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .data_byte_i (byte_data),
    .byte_pos_i  (byte_pos),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .pixel_o     (pixel_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // per-channel 5/6/5 mix of a and b with weight t out of 15
  function automatic logic [PIX_W-1:0] mix565(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input int unsigned t);
    int unsigned red, grn, blu;
    red = (int'(a[15:11]) * t + int'(b[15:11]) * (15 - t)) / 15;
    grn = (int'(a[10:5]) * t + int'(b[10:5]) * (15 - t)) / 15;
    blu = (int'(a[4:0]) * t + int'(b[4:0]) * (15 - t)) / 15;
    return {red[4:0], grn[5:0], blu[4:0]};
  endfunction

  // expected display pixel for one accepted byte request, if any
  function automatic void predict_masked_pixel(input logic [BYTE_W-1:0] b,
                                               input logic [POS_W-1:0] pos);
    int unsigned idx, col, row, s;
    int dx, dy, d;
    logic [PIX_W-1:0] pix, res;
    if (!pos[0]) begin
      saved_high_byte = b;
      return;
    end
    idx = int'(pos >> 1);
    col = idx % IMAGE_SIZE;
    row = idx / IMAGE_SIZE;
    if (col < win_col_lo || col > win_col_hi || row < win_row_lo || row > win_row_hi)
      return;
    pix = {saved_high_byte, b};
    dx  = int'(col) - CTR;
    dy  = int'(row) - CTR;
    d   = dx * dx + dy * dy;
    if (d < RING_LO) begin
      res = pix;
    end else if (d > RING_HI) begin
      res = outside_rgb;
    end else begin
      s = (31 * (d - RING_LO)) / (RING_HI - RING_LO);
      if (s >= 16) res = mix565(outside_rgb, ring_rgb, s - 16);
      else res = mix565(ring_rgb, pix, s);
    end
    expected_pixels.push_back(res);
  endfunction

  // queue the two byte requests that make one pixel
  function automatic void queue_pixel(input int unsigned col, input int unsigned row,
                                      input logic [BYTE_W-1:0] hi,
                                      input logic [BYTE_W-1:0] lo);
    int unsigned idx;
    idx = row * IMAGE_SIZE + col;
    byte_reqs_pending.push_back('{data: hi, pos: POS_W'(2 * idx)});
    byte_reqs_pending.push_back('{data: lo, pos: POS_W'(2 * idx + 1)});
  endfunction

  // pixel index inside the image, half the time drawn toward the border ring
  function automatic int unsigned pick_pixel_index();
    int unsigned col, row;
    int dx, dy, d;
    col = $urandom_range(IMAGE_SIZE - 1);
    row = $urandom_range(IMAGE_SIZE - 1);
    if ($urandom_range(1) == 1) begin
      for (int k = 0; k < 64; k++) begin
        dx = int'(col) - CTR;
        dy = int'(row) - CTR;
        d  = dx * dx + dy * dy;
        if (d >= RING_LO - 64 && d <= RING_HI + 64) break;
        col = $urandom_range(IMAGE_SIZE - 1);
        row = $urandom_range(IMAGE_SIZE - 1);
      end
    end
    return row * IMAGE_SIZE + col;
  endfunction

  // random mix of pixel pairs, short scan runs and stray bytes
  function automatic void queue_random_bytes(input int count);
    int n, pick, run_len;
    int unsigned idx;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        idx = pick_pixel_index();
        queue_pixel(idx % IMAGE_SIZE, idx / IMAGE_SIZE, BYTE_W'($urandom),
                    BYTE_W'($urandom));
        n += 2;
      end else if (pick < 82) begin
        idx = pick_pixel_index();
        if (idx > 20700) idx = 20700;
        run_len = $urandom_range(8, 2);
        for (int k = 0; k < run_len; k++)
          queue_pixel((idx + k) % IMAGE_SIZE, (idx + k) / IMAGE_SIZE, BYTE_W'($urandom),
                      BYTE_W'($urandom));
        n += 2 * run_len;
      end else begin
        byte_reqs_pending.push_back('{data: BYTE_W'($urandom),
            pos: ($urandom_range(7) == 0) ? POS_W'($urandom_range(65535))
                                          : POS_W'($urandom_range(41471))});
        n += 1;
      end
    end
  endfunction

  // write every register, plus the spare indexes, one per cycle
  task automatic set_config(input logic [PIX_W-1:0] fg, input logic [PIX_W-1:0] bg,
                            input logic [CROP_W-1:0] x_lo, input logic [CROP_W-1:0] x_hi,
                            input logic [CROP_W-1:0] y_lo, input logic [CROP_W-1:0] y_hi);
    logic [CFG_IDX_W-1:0]  regs [8];
    logic [CFG_DATA_W-1:0] vals [8];
    regs = '{CFG_FG, CFG_BG, CFG_X_MIN, CFG_X_MAX, CFG_Y_MIN, CFG_Y_MAX,
             CFG_SPARE_LO, CFG_SPARE_HI};
    vals = '{fg, bg, CFG_DATA_W'(x_lo), CFG_DATA_W'(x_hi), CFG_DATA_W'(y_lo),
             CFG_DATA_W'(y_hi), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we      <= 1'b0;
    ring_rgb    = fg;
    outside_rgb = bg;
    win_col_lo  = x_lo;
    win_col_hi  = x_hi;
    win_row_lo  = y_lo;
    win_row_hi  = y_hi;
    settings_run++;
  endtask

  // block idle: all requests taken, all pixels back, in-flight work settled
  task automatic wait_idle();
    while (byte_reqs_pending.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        predict_masked_pixel(byte_data, byte_pos);
        bytes_sent++;
      end
      if (!in_valid || in_ready_o) begin
        if (byte_reqs_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_req = byte_reqs_pending.pop_front();
          in_valid  <= 1'b1;
          byte_data <= next_req.data;
          byte_pos  <= next_req.pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (expected_pixels.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("ERROR: pixel %h with nothing expected", pixel_o);
          mismatch_count++;
        end else begin
          want_pixel = expected_pixels.pop_front();
          pixels_checked++;
          if (pixel_o !== want_pixel) begin
            if (mismatch_count < MAX_REPORTS)
              $display("ERROR: pixel %0d expected %h got %h", pixels_checked, want_pixel,
                       pixel_o);
            mismatch_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected", cycle_count,
               expected_pixels.size());
      $display("circular_avatar_mask test failed");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: odd byte with no high byte yet, then byte extremes at the corner and the center
    byte_reqs_pending.push_back('{data: 8'h5A, pos: 16'd20881});
    queue_pixel(0, 0, 8'hFF, 8'hFF);
    queue_pixel(CTR, CTR, 8'hFF, 8'hFF);
    queue_pixel(CTR, CTR, 8'h00, 8'h00);
    wait_idle();

    // border ring points along the center row, the far corner, rows past the image
    set_config(16'hFFFF, 16'h0000, 8'd0, 8'd143, 8'd0, 8'd143);
    queue_pixel(140, CTR, 8'hA5, 8'h5A);  // on the inner edge of the ring
    queue_pixel(141, CTR, 8'h12, 8'h34);  // blend toward the ring color
    queue_pixel(142, CTR, 8'h87, 8'h65);
    queue_pixel(143, CTR, 8'h0F, 8'hF0);  // blend toward the background
    queue_pixel(0, CTR, 8'hC3, 8'h3C);    // on the outer edge
    queue_pixel(143, 143, 8'h55, 8'hAA);
    byte_reqs_pending.push_back('{data: 8'h77, pos: 16'd65534});
    byte_reqs_pending.push_back('{data: 8'h88, pos: 16'd65535});
    byte_reqs_pending.push_back('{data: 8'h99, pos: 16'd41473});
    wait_idle();

    // random phases, each under its own register settings, with one of three idle patterns
    for (int phase = 0; phase < 6; phase++) begin
      logic [CROP_W-1:0] x_lo, x_hi, y_lo, y_hi;
      x_lo = CROP_W'($urandom_range(100));
      x_hi = CROP_W'($urandom_range(143, x_lo));
      y_lo = CROP_W'($urandom_range(100));
      y_hi = CROP_W'($urandom_range(143, y_lo));
      case (phase)
        0: set_config(PIX_W'($urandom), PIX_W'($urandom), 8'd0, 8'd143, 8'd0, 8'd143);
        1: set_config(16'hFFFF, 16'h0000, 8'd40, 8'd143, 8'd0, 8'd100);
        2: set_config(16'h0000, 16'hFFFF, x_lo, x_hi, y_lo, y_hi);
        3: set_config(PIX_W'($urandom), PIX_W'($urandom), 8'd120, 8'd30, 8'd0,
                      8'd143);  // empty window
        4: set_config(16'hF81F, 16'h07E0, 8'd0, 8'd143, 8'd0, 8'd143);
        default: set_config(PIX_W'($urandom), PIX_W'($urandom), x_lo, x_hi, y_lo, y_hi);
      endcase
      if (phase < 2) begin
        send_gap_pct   = 35;
        recv_stall_pct = 62;
      end else if (phase < 4) begin
        send_gap_pct   = 62;
        recv_stall_pct = 35;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      queue_random_bytes((phase == 3) ? 60 : 190);
      wait_idle();
    end

    $display("covered %0d byte requests and %0d checked pixels under %0d register settings",
             bytes_sent, pixels_checked, settings_run);
    $display("ring blends, crop windows incl. an empty one, rows past the image, ",
             "stray bytes and both stall patterns");
    if (mismatch_count == 0) begin
      $display("circular_avatar_mask test passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("circular_avatar_mask test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/cam_pkg.sv
hw/rtl/cam_regs.sv
hw/rtl/cam_dp.sv
hw/rtl/cam_ctrl.sv
hw/rtl/circular_avatar_mask.sv
dv/tb_circular_avatar_mask.sv
